// ===== rtl/i2d_pkg.sv =====
package i2d_pkg;

  // Default and fixed widths.
  localparam int WORD_BITS_DEF = 32;
  localparam int IN_WORD_W     = 32;
  localparam int CHAR_W        = 8;

  // Binary bits consumed by one double-dabble pipeline stage.
  localparam int DAB_BITS = 4;

  // Selector codes.
  localparam logic OP_SIGNED   = 1'b0;
  localparam logic OP_UNSIGNED = 1'b1;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Number of decimal digits needed for any value of the given bit count,
  // ceil(bits * log10(2)).
  function automatic int dec_digits(input int bits);
    return (bits * 30103 + 99999) / 100000;
  endfunction

endpackage

// ===== rtl/i2d_magnitude.sv =====
module i2d_magnitude
  import i2d_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int PAD       = WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [IN_WORD_W-1:0] in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_neg,
  output logic [PAD-1:0]       out_mag
);

  logic [WORD_BITS-1:0] value;
  logic                 neg_nxt;
  logic [WORD_BITS-1:0] mag_nxt;
  logic                 valid_r;
  logic                 neg_r;
  logic [PAD-1:0]       mag_r;
  logic                 take;

  generate
    if (WORD_BITS <= IN_WORD_W) begin : g_trunc
      assign value = in_word[WORD_BITS-1:0];
    end else begin : g_ext
      assign value = {{(WORD_BITS-IN_WORD_W){1'b0}}, in_word};
    end
  endgenerate

  // The magnitude is taken as an unsigned value, so the most negative
  // signed word keeps its full magnitude.
  always_comb begin
    neg_nxt = (in_op == OP_SIGNED) && value[WORD_BITS-1];
    mag_nxt = neg_nxt ? (~value + {{(WORD_BITS-1){1'b0}}, 1'b1}) : value;
  end

  assign in_stall = valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      neg_r <= neg_nxt;
      mag_r <= PAD'(mag_nxt);
    end
  end

  assign out_valid = valid_r;
  assign out_neg   = neg_r;
  assign out_mag   = mag_r;

endmodule

// ===== rtl/i2d_dabble_stage.sv =====
module i2d_dabble_stage
  import i2d_pkg::*;
#(
  parameter int NDIG = dec_digits(WORD_BITS_DEF),
  parameter int PAD  = WORD_BITS_DEF,
  parameter int SRW  = NDIG * 4 + PAD
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_neg,
  input  logic [SRW-1:0] in_sr,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_neg,
  output logic [SRW-1:0] out_sr
);

  logic [SRW-1:0] sr_nxt;
  logic           valid_r;
  logic           neg_r;
  logic [SRW-1:0] sr_r;
  logic           take;

  // Shift-and-add-3: before each shift, every BCD digit of five or more
  // gets three added so that it carries correctly into the next digit.
  always_comb begin
    sr_nxt = in_sr;
    for (int b = 0; b < DAB_BITS; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (sr_nxt[PAD + 4*d +: 4] >= 4'd5) begin
          sr_nxt[PAD + 4*d +: 4] = sr_nxt[PAD + 4*d +: 4] + 4'd3;
        end
      end
      sr_nxt = sr_nxt << 1;
    end
  end

  assign in_stall = valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      neg_r <= in_neg;
      sr_r  <= sr_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_neg   = neg_r;
  assign out_sr    = sr_r;

endmodule

// ===== rtl/i2d_serializer.sv =====
module i2d_serializer
  import i2d_pkg::*;
#(
  parameter int NDIG = dec_digits(WORD_BITS_DEF)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_neg,
  input  logic [NDIG*4-1:0] in_bcd,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_last
);

  localparam int IW = $clog2(NDIG);

  logic [IW-1:0]          lead_idx;
  logic                   wk_valid_r;
  logic                   wk_neg_r;
  logic [IW-1:0]          wk_idx_r;
  logic [NDIG-1:0][3:0]   wk_bcd_r;
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;
  logic [CHAR_W-1:0]      char_nxt;
  logic                   last_nxt;
  logic                   emit;
  logic                   done;
  logic                   take;

  // Position of the most significant nonzero digit; zero prints one '0'.
  always_comb begin
    lead_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (in_bcd[4*d +: 4] != 4'd0) begin
        lead_idx = IW'(d);
      end
    end
  end

  always_comb begin
    char_nxt = wk_neg_r ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, wk_bcd_r[wk_idx_r]});
    last_nxt = !wk_neg_r && (wk_idx_r == '0);
  end

  assign emit     = wk_valid_r && (!out_valid_r || !out_stall);
  assign done     = emit && last_nxt;
  assign in_stall = wk_valid_r && !done;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        wk_valid_r <= 1'b1;
      end else if (done) begin
        wk_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wk_neg_r <= in_neg;
      wk_idx_r <= lead_idx;
      wk_bcd_r <= in_bcd;
    end else if (emit) begin
      if (wk_neg_r) begin
        wk_neg_r <= 1'b0;
      end else begin
        wk_idx_r <= wk_idx_r - IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= char_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

endmodule

// ===== rtl/integer_to_decimal_ascii.sv =====
// Converts one binary word per request into its decimal ASCII text.
// Input channel: in_valid/in_stall with in_op (0 = signed, 1 = unsigned) and
// in_word. Only the low WORD_BITS bits of the word are used.
// Output channel: out_valid/out_stall, one character per request on
// out_char_out, most significant digit first, with out_last on the final
// character. A negative signed value starts with '-'; zero gives one '0'.
// A request is taken on a rising edge where valid is high and stall is low.
// The pipeline takes a new word in every cycle unless the input is stalled;
// the sustained rate is set by the one-character output register, which
// shows one character of a word at a time (1 to 11 characters at 32 bits).
// Reset (rst_n low, synchronous) empties every stage and the output.
// When the receiver stalls, the shown character holds and the pipeline
// fills up behind it, then stalls the input; nothing is lost or repeated.
module integer_to_decimal_ascii
  import i2d_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [IN_WORD_W-1:0] in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAR_W-1:0]    out_char_out,
  output logic                 out_last
);

  // Decimal digits in the widest value, double-dabble stages, and the
  // binary width rounded up to a whole number of stages.
  localparam int NDIG = dec_digits(WORD_BITS);
  localparam int NSTG = (WORD_BITS + DAB_BITS - 1) / DAB_BITS;
  localparam int PAD  = NSTG * DAB_BITS;
  localparam int BCDW = NDIG * 4;
  localparam int SRW  = BCDW + PAD;

  logic           mag_valid;
  logic           mag_stall;
  logic           mag_neg;
  logic [PAD-1:0] mag;

  // Stage k of these arrays is the input of dabble stage k; the last entry
  // feeds the character serializer.
  logic           stg_valid [0:NSTG];
  logic           stg_stall [0:NSTG];
  logic           stg_neg   [0:NSTG];
  logic [SRW-1:0] stg_sr    [0:NSTG];

  // First stage: sign detection and magnitude.
  i2d_magnitude #(
    .WORD_BITS(WORD_BITS),
    .PAD      (PAD)
  ) u_mag (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_word  (in_word),
    .out_valid(mag_valid),
    .out_stall(mag_stall),
    .out_neg  (mag_neg),
    .out_mag  (mag)
  );

  // The shift register holds the BCD digits above the binary magnitude;
  // the digits start at zero.
  assign stg_valid[0] = mag_valid;
  assign mag_stall    = stg_stall[0];
  assign stg_neg[0]   = mag_neg;
  assign stg_sr[0]    = SRW'(mag);

  // Binary to BCD, four bits per stage.
  generate
    for (genvar k = 0; k < NSTG; k++) begin : g_dab
      i2d_dabble_stage #(
        .NDIG(NDIG),
        .PAD (PAD),
        .SRW (SRW)
      ) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stg_valid[k]),
        .in_stall (stg_stall[k]),
        .in_neg   (stg_neg[k]),
        .in_sr    (stg_sr[k]),
        .out_valid(stg_valid[k+1]),
        .out_stall(stg_stall[k+1]),
        .out_neg  (stg_neg[k+1]),
        .out_sr   (stg_sr[k+1])
      );
    end
  endgenerate

  // Sign and digits leave one character per cycle through the output
  // register while the receiver does not stall.
  i2d_serializer #(
    .NDIG(NDIG)
  ) u_ser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (stg_valid[NSTG]),
    .in_stall    (stg_stall[NSTG]),
    .in_neg      (stg_neg[NSTG]),
    .in_bcd      (stg_sr[NSTG][SRW-1 -: BCDW]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char_out(out_char_out),
    .out_last    (out_last)
  );

endmodule

// ===== rtl/i2d_checker.sv =====
module i2d_checker
  import i2d_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_char_out,
  input logic              out_last
);

  logic out_acc;
  logic first_r;
  logic after_minus_r;

  assign out_acc = out_valid && !out_stall;

  // Tracks where the next delivered character sits in its number's text.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r       <= 1'b1;
      after_minus_r <= 1'b0;
    end else if (out_acc) begin
      first_r       <= out_last;
      after_minus_r <= (out_char_out == CHAR_MINUS);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_out) && $stable(out_last))
    else $error("stalled character changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("character shown after reset");

  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_out == CHAR_MINUS) ||
                  ((out_char_out >= CHAR_ZERO) && (out_char_out <= CHAR_ZERO + 8'd9)))
    else $error("character is neither a digit nor a minus sign");

  a_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_out == CHAR_MINUS) |-> !out_last && first_r && !after_minus_r)
    else $error("minus sign out of place");

  a_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (first_r || after_minus_r) && (out_char_out == CHAR_ZERO)
      |-> out_last && !after_minus_r)
    else $error("leading zero in decimal text");

endmodule

bind integer_to_decimal_ascii i2d_checker u_i2d_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_char_out(out_char_out),
  .out_last    (out_last)
);

// ===== tb/sv/testbench.sv =====
module testbench;
  import i2d_pkg::*;

  // One word request as the sender queues it. When hold is set, the sender
  // keeps that request back until every character already owed has arrived.
  typedef struct packed {
    logic                 hold;
    logic                 op;
    logic [IN_WORD_W-1:0] word;
  } word_req_t;

  // One character of decimal text as the receiver should see it.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // Receiver stall patterns. Each one runs for a random stretch of cycles.
  localparam int STALL_NONE   = 0;
  localparam int STALL_HALF   = 1;
  localparam int STALL_SPARSE = 2;
  localparam int STALL_HEAVY  = 3;

  localparam int RANDOM_REQS = 390;
  // The limit covers the slowest correct run several times over: 410 words
  // of up to 11 characters, each character waiting out the heavy stall
  // pattern, plus sender gaps and the pipeline fill.
  localparam int CYCLE_LIMIT = 500000;
  // The tail window outlasts the path from input to first character at 32
  // bits, so that a stray character shows up.
  localparam int TAIL_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_op = OP_SIGNED;
  logic [IN_WORD_W-1:0] in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_W-1:0]    out_char_out;
  logic                 out_last;

  word_req_t  pending_words[$];
  text_char_t expected_text[$];

  int mismatch_count = 0;
  int accepted_count = 0;
  int queued_count = 0;
  int cycle_count = 0;

  integer_to_decimal_ascii u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Prints one line per mismatch and keeps a count; the run carries on.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Works out the decimal text of one accepted request and appends it to the
  // characters still owed. In signed mode a set top bit means negative: the
  // text gets a leading minus and the magnitude is the two's complement taken
  // as an unsigned number, so the most negative word needs no special path.
  // Zero still yields one digit because the digit loop runs at least once.
  function automatic void owe_decimal_text(input logic op,
                                           input logic [IN_WORD_W-1:0] word);
    logic [IN_WORD_W-1:0] magnitude;
    logic [3:0]           digits[$];
    text_char_t           c;
    magnitude = word;
    if (op == OP_SIGNED && word[IN_WORD_W-1]) begin
      c.ch   = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
      magnitude = ~word + IN_WORD_W'(1);
    end
    do begin
      digits.push_front(4'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    foreach (digits[i]) begin
      c.ch   = CHAR_ZERO + CHAR_W'(digits[i]);
      c.last = (i == digits.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  task automatic queue_word(input logic op, input logic [IN_WORD_W-1:0] word,
                            input logic hold);
    word_req_t r;
    r.hold = hold;
    r.op   = op;
    r.word = word;
    pending_words.push_back(r);
    queued_count++;
  endtask

  // Stimulus and end of run. The directed words cover both selector values on
  // zero, one, all ones, the most negative value and its neighbors (8000_0001
  // signed only) and digit-count boundaries around powers of ten. Random
  // words are full range, of random bit length, next to powers of ten in
  // either sign, small in either sign, or near the signed extremes.
  initial begin
    logic [IN_WORD_W-1:0] pow10[10];
    logic [IN_WORD_W-1:0] w;
    logic                 op;
    pow10[0] = 1;
    for (int k = 1; k < 10; k++) pow10[k] = pow10[k-1] * 10;

    queue_word(OP_SIGNED,   32'h0000_0000, 1'b0);
    queue_word(OP_UNSIGNED, 32'h0000_0000, 1'b0);
    queue_word(OP_SIGNED,   32'h0000_0001, 1'b0);
    queue_word(OP_UNSIGNED, 32'h0000_0001, 1'b0);
    queue_word(OP_SIGNED,   32'hFFFF_FFFF, 1'b0);
    queue_word(OP_UNSIGNED, 32'hFFFF_FFFF, 1'b0);
    queue_word(OP_SIGNED,   32'h8000_0000, 1'b0);
    queue_word(OP_UNSIGNED, 32'h8000_0000, 1'b0);
    queue_word(OP_SIGNED,   32'h8000_0001, 1'b0);
    queue_word(OP_SIGNED,   32'h7FFF_FFFF, 1'b0);
    queue_word(OP_UNSIGNED, 32'h7FFF_FFFF, 1'b0);
    queue_word(OP_SIGNED,   32'd9, 1'b0);
    queue_word(OP_SIGNED,   32'd10, 1'b0);
    queue_word(OP_UNSIGNED, 32'd99, 1'b0);
    queue_word(OP_UNSIGNED, 32'd100, 1'b0);
    queue_word(OP_SIGNED,   32'hFFFF_FFF6, 1'b0);
    queue_word(OP_UNSIGNED, 32'd999_999_999, 1'b0);
    queue_word(OP_UNSIGNED, 32'd1_000_000_000, 1'b0);
    queue_word(OP_SIGNED,   32'd1_000_000_000, 1'b0);
    queue_word(OP_SIGNED,   -32'sd1_000_000_000, 1'b0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      op = OP_UNSIGNED;
      if ($urandom_range(0, 1) == 0) op = OP_SIGNED;
      case ($urandom_range(0, 4))
        0: w = $urandom;
        1: w = $urandom >> $urandom_range(0, 31);
        2: begin
          w = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
          if ($urandom_range(0, 1) == 0) w = -w;
        end
        3: begin
          w = $urandom_range(0, 20);
          if ($urandom_range(0, 1) == 0) w = -w;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) w = 32'h8000_0000 + $urandom_range(0, 3);
          else w = 32'h7FFF_FFFF - $urandom_range(0, 3);
        end
      endcase
      // Every hundred words the sender lets the output run dry first.
      queue_word(op, w, (n % 100) == 50);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < queued_count || expected_text.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Sender. A request that was accepted at this edge is predicted from the
  // values still on the bus. While a request sits stalled nothing moves;
  // otherwise the next one is put up unless a gap between bursts is running
  // or the next request is held until the output has drained.
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin : drive_requests
    word_req_t nxt;
    logic      send;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        owe_decimal_text(in_op, in_word);
        accepted_count++;
      end
      if (!(in_valid && in_stall)) begin
        send = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].hold && expected_text.size() > 0)) begin
          nxt = pending_words.pop_front();
          send = 1'b1;
          in_op   <= nxt.op;
          in_word <= nxt.word;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            // Mostly short gaps, now and then a long one, sometimes none.
            if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 15);
            else gap_left = $urandom_range(0, 2);
          end
        end
        in_valid <= send;
      end
    end
  end

  // Receiver stall pattern: a mode is drawn for a random stretch, from no
  // stalls at all through sparse and even stalls to heavy back-pressure that
  // lets the pipeline fill up and push back on the sender.
  int stall_mode = STALL_NONE;
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_HALF:   out_stall <= ($urandom_range(0, 1) == 0);
        STALL_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
        default:      out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Checker. Every character taken from the output is compared with the
  // oldest one still owed.
  always @(posedge clk) begin : check_text
    text_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected character 8'h%02h last=%0b",
                                  out_char_out, out_last));
      end else begin
        want = expected_text.pop_front();
        if (out_char_out !== want.ch)
          report_mismatch($sformatf("character 8'h%02h, want 8'h%02h",
                                    out_char_out, want.ch));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b on character 8'h%02h",
                                    out_last, want.last, want.ch));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d characters still owed", expected_text.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/i2d_pkg.sv
rtl/i2d_magnitude.sv
rtl/i2d_dabble_stage.sv
rtl/i2d_serializer.sv
rtl/integer_to_decimal_ascii.sv
rtl/i2d_checker.sv
tb/sv/testbench.sv
